>>> hdl/sitda_pkg.sv
// Shared widths and character codes for the signed integer to decimal text block.
// No dependencies; compiled first.
package sitda_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 8;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CHAR_W-1:0]         char_t;
    typedef logic [BCD_W-1:0]          bcd_t;

endpackage

>>> hdl/sitda_value_if.sv
// Request channel carrying one signed integer to convert.
// Depends on sitda_pkg.
interface sitda_value_if;
    logic              valid;
    logic              ready;
    sitda_pkg::value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> hdl/sitda_text_if.sv
// Request channel carrying one ASCII character of the decimal text.
// Depends on sitda_pkg.
interface sitda_text_if;
    logic             valid;
    logic             ready;
    sitda_pkg::char_t character;
    logic             last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

>>> hdl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Depends on sitda_pkg, sitda_value_if, sitda_text_if.
//
// One value is taken when value_ch.ready is high; ready stays low until the
// converter has loaded its last character into the output register. The
// magnitude is turned into ten BCD digits by a shift-and-add-3 loop, one bit
// per cycle, then leading zero digits are shifted out one per cycle, with a
// last STRIP step that finds the leading digit, then one character per cycle
// leaves through a registered output while text_ch.ready is high: minus sign
// first for a negative value, digits most significant first, last_char on
// the final digit.
module signed_int_to_decimal_ascii (
    input  logic         clk,
    input  logic         rst_n,
    sitda_value_if.sink  value_ch,
    sitda_text_if.source text_ch
);
    import sitda_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        CONV,
        STRIP,
        EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_W-1:0]      mag_reg, mag_next;
    bcd_t                    bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]    dig_cnt_reg, dig_cnt_next;
    logic                    sign_reg, sign_next;
    logic                    out_valid_reg, out_valid_next;
    char_t                   out_char_reg, out_char_next;
    logic                    out_last_reg, out_last_next;

    bcd_t                    bcd_adj;
    logic [VALUE_W-1:0]      raw;
    logic                    out_free;

    assign raw      = VALUE_W'(value_ch.value);
    assign out_free = !out_valid_reg || text_ch.ready;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && !text_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            IDLE:
            begin
                if (value_ch.valid)
                begin
                    sign_next    = raw[VALUE_W-1];
                    mag_next     = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = CONV;
                end
            end
            CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    dig_cnt_next = DIG_CNT_W'(DIGITS);
                    state_next   = STRIP;
                end
            end
            STRIP:
            begin
                if (bcd_reg[BCD_W-1 -: 4] == 4'd0 && dig_cnt_reg > DIG_CNT_W'(1))
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else
                    state_next = EMIT;
            end
            EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        out_char_next = CHAR_MINUS;
                        out_last_next = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else
                    begin
                        out_char_next = CHAR_ZERO + CHAR_W'(bcd_reg[BCD_W-1 -: 4]);
                        out_last_next = (dig_cnt_reg == DIG_CNT_W'(1));
                        bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                        dig_cnt_next  = dig_cnt_reg - DIG_CNT_W'(1);
                        if (dig_cnt_reg == DIG_CNT_W'(1))
                            state_next = IDLE;
                    end
                end
            end
            default:
                state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            sign_reg      <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_reg      <= sign_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign value_ch.ready    = (state_reg == IDLE);
    assign text_ch.valid     = out_valid_reg;
    assign text_ch.character = out_char_reg;
    assign text_ch.last_char = out_last_reg;

`ifndef SYNTHESIS
    // accepted request starts conversion
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        value_ch.valid && value_ch.ready |=> state_reg == CONV)
        else $error("request accepted but conversion not started");

    // only minus sign or a digit leaves the block
    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        text_ch.valid |-> (text_ch.character == CHAR_MINUS ||
            (text_ch.character >= CHAR_ZERO && text_ch.character <= CHAR_ZERO + 8'd9)))
        else $error("character out of range");

    // minus sign is never the final character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        text_ch.valid && text_ch.character == CHAR_MINUS |-> !text_ch.last_char)
        else $error("minus sign flagged last");

    // digit count stays within the digit buffer while stripping and emitting
    a_dig_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == STRIP || state_reg == EMIT) |->
            (dig_cnt_reg >= DIG_CNT_W'(1) && dig_cnt_reg <= DIG_CNT_W'(DIGITS)))
        else $error("digit count out of range");
`endif

endmodule
